/* rtl/core/prhs_pkg.sv */
// Package: widths, constants and the queue entry type for the rectangle hit selector.
`timescale 1ns / 1ps
`default_nettype none
package prhs_pkg;

  localparam int MAX_RECTS   = 256;
  localparam int COORD_BITS  = 16;
  localparam int IDX_BITS    = 8;
  localparam int DIST_BITS   = 2 * COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        span_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [DIST_BITS-1:0]         dist_t;
  typedef logic [SQ_BITS-1:0]           sq_t;

  // One classified rectangle, handed from the front to the back
  typedef struct packed {
    logic  covers;
    logic  last;
    idx_t  pos;
    span_t depth;
    span_t dx;
    span_t dy;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/prhs_if.sv */
// Interfaces: rectangle input channel and selection result channel.
`timescale 1ns / 1ps
`default_nettype none
interface prhs_rect_if import prhs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t rect_left;
  coord_t rect_top;
  coord_t rect_right;
  coord_t rect_bottom;
  coord_t point_x;
  coord_t point_y;
  logic   last_rect;

  modport source (output valid, rect_left, rect_top, rect_right, rect_bottom,
                  point_x, point_y, last_rect, input ready);
  modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom,
                  point_x, point_y, last_rect, output ready);
endinterface

interface prhs_hit_if import prhs_pkg::*; ();
  logic valid;
  logic ready;
  idx_t rect_index;
  logic point_inside;

  modport source (output valid, rect_index, point_inside, input ready);
  modport sink   (input valid, rect_index, point_inside, output ready);
endinterface
`default_nettype wire

/* rtl/core/prhs_front.sv */
// Front: accepts rectangle beats, numbers them and classifies the point against each.
`timescale 1ns / 1ps
`default_nettype none
module prhs_front import prhs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  prhs_rect_if.sink   rect,
  output entry_t      entry,
  output logic        entry_valid,
  input  wire logic   entry_full
);

  idx_t   cnt;
  entry_t entry_next;
  logic   push;
  logic   take;

  coord_t lox, hix, loy, hiy;
  logic   in_span, covers;
  span_t  d_xl, d_xh, d_yl, d_yh, d_x, d_y, d_min;
  span_t  out_dx, out_dy;

  // Signed difference a - b known to be in 0..2^COORD_BITS-1
  function automatic span_t udiff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] s;
    s = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return s[COORD_BITS-1:0];
  endfunction

  assign push       = entry_valid && !entry_full;
  assign rect.ready = !entry_valid || push;
  assign take       = rect.valid && rect.ready;

  // Classification of the point against the rectangle
  always_comb begin
    lox = (rect.rect_left < rect.rect_right)  ? rect.rect_left  : rect.rect_right;
    hix = (rect.rect_left < rect.rect_right)  ? rect.rect_right : rect.rect_left;
    loy = (rect.rect_top  < rect.rect_bottom) ? rect.rect_top   : rect.rect_bottom;
    hiy = (rect.rect_top  < rect.rect_bottom) ? rect.rect_bottom : rect.rect_top;

    covers  = (rect.rect_left <= rect.point_x) && (rect.point_x < rect.rect_right) &&
              (rect.rect_top <= rect.point_y) && (rect.point_y < rect.rect_bottom);
    in_span = (rect.point_x >= lox) && (rect.point_x <= hix) &&
              (rect.point_y >= loy) && (rect.point_y <= hiy);

    d_xl  = udiff(rect.point_x, lox);
    d_xh  = udiff(hix, rect.point_x);
    d_yl  = udiff(rect.point_y, loy);
    d_yh  = udiff(hiy, rect.point_y);
    d_x   = (d_xl < d_xh) ? d_xl : d_xh;
    d_y   = (d_yl < d_yh) ? d_yl : d_yh;
    d_min = (d_x < d_y) ? d_x : d_y;

    // clamped box distance for a point outside the closed span
    if (rect.point_x < lox)      out_dx = udiff(lox, rect.point_x);
    else if (rect.point_x > hix) out_dx = udiff(rect.point_x, hix);
    else                         out_dx = '0;
    if (rect.point_y < loy)      out_dy = udiff(loy, rect.point_y);
    else if (rect.point_y > hiy) out_dy = udiff(rect.point_y, hiy);
    else                         out_dy = '0;

    entry_next.covers = covers;
    entry_next.last   = rect.last_rect;
    entry_next.pos    = cnt;
    entry_next.depth  = d_min;
    entry_next.dx     = in_span ? d_min : out_dx;
    entry_next.dy     = in_span ? '0    : out_dy;
  end

  // Stage register and saturating position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      cnt         <= '0;
    end else begin
      if (take) begin
        entry_valid <= 1'b1;
        if (rect.last_rect) cnt <= '0;
        else if (cnt < IDX_BITS'(MAX_RECTS - 1)) cnt <= cnt + 1'b1;
      end else if (push) begin
        entry_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) entry <= entry_next;
  end

  a_cnt_restart: assert property (@(posedge clk) disable iff (rst)
    (take && rect.last_rect) |=> (cnt == '0))
    else $error("position counter did not restart after last beat");

endmodule
`default_nettype wire

/* rtl/core/prhs_queue.sv */
// Queue: short FIFO of classified rectangles between front and back.
`timescale 1ns / 1ps
`default_nettype none
module prhs_queue import prhs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        not_empty
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

/* rtl/core/prhs_back.sv */
// Back: squares the distances, keeps the running best and emits one beat per run.
`timescale 1ns / 1ps
`default_nettype none
module prhs_back import prhs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t q_data,
  input  wire logic   q_valid,
  output logic        q_pop,
  prhs_hit_if.source  hit
);

  logic   en;
  logic   s1_valid;
  entry_t s1;
  sq_t    sq_x, sq_y;
  dist_t  dsq;

  logic   have_inner, have_inner_next;
  span_t  best_depth, best_depth_next;
  idx_t   inner_idx, inner_idx_next;
  dist_t  best_dist, best_dist_next;
  idx_t   outer_idx, outer_idx_next;

  assign en    = !hit.valid || hit.ready;
  assign q_pop = q_valid && en;
  assign dsq   = DIST_BITS'(sq_x) + DIST_BITS'(sq_y);

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1   <= q_data;
      sq_x <= q_data.dx * q_data.dx;
      sq_y <= q_data.dy * q_data.dy;
    end
  end

  // Running best selection
  always_comb begin
    have_inner_next = have_inner;
    best_depth_next = best_depth;
    inner_idx_next  = inner_idx;
    best_dist_next  = best_dist;
    outer_idx_next  = outer_idx;
    if (s1_valid) begin
      if (s1.covers) begin
        if (!have_inner || s1.depth > best_depth) begin
          have_inner_next = 1'b1;
          best_depth_next = s1.depth;
          inner_idx_next  = s1.pos;
        end
      end else if (dsq < best_dist) begin
        best_dist_next = dsq;
        outer_idx_next = s1.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_inner <= 1'b0;
      best_depth <= '0;
      inner_idx  <= '0;
      best_dist  <= '1;
      outer_idx  <= '0;
      hit.valid  <= 1'b0;
    end else if (en) begin
      hit.valid <= s1_valid && s1.last;
      if (s1_valid && s1.last) begin
        have_inner <= 1'b0;
        best_depth <= '0;
        inner_idx  <= '0;
        best_dist  <= '1;
        outer_idx  <= '0;
      end else begin
        have_inner <= have_inner_next;
        best_depth <= best_depth_next;
        inner_idx  <= inner_idx_next;
        best_dist  <= best_dist_next;
        outer_idx  <= outer_idx_next;
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (en && s1_valid && s1.last) begin
      hit.rect_index   <= have_inner_next ? inner_idx_next : outer_idx_next;
      hit.point_inside <= have_inner_next;
    end
  end

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1.last) |=> (!have_inner && best_dist == '1))
    else $error("run state not cleared after result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s1_valid) && $stable(best_dist) && $stable(have_inner)))
    else $error("back pipeline moved while result beat stalled");

endmodule
`default_nettype wire

/* rtl/core/point_rectangle_hit_select.sv */
// Top level: picks one rectangle of a run for a query point.
// Path of a result beat: front register, queue, square stage, then result register.
// Throughput: one rectangle per cycle; the back takes a stall only while a result waits.
// The four-entry queue lets the front keep accepting while the back is held.
// Synchronous active-high rst clears all run state, queue and valid flags.
`timescale 1ns / 1ps
`default_nettype none
module point_rectangle_hit_select import prhs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  prhs_rect_if.sink  rect,
  prhs_hit_if.source hit
);

  entry_t f_entry;
  logic   f_valid;
  logic   q_full;
  entry_t q_data;
  logic   q_valid;
  logic   q_pop;

  prhs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .rect        (rect),
    .entry       (f_entry),
    .entry_valid (f_valid),
    .entry_full  (q_full)
  );

  prhs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  prhs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .hit     (hit)
  );

endmodule
`default_nettype wire
